// File: rtl/core/sshb_pkg.sv
// sshb_pkg: widths, fixed-point constants, divider request/response types and
// the shared rounding helper of the stereo sample-and-hold bitcrusher.
// No dependencies.
`default_nettype none

package sshb_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int KNOB_BITS   = 16;

    localparam int KNOB_ONE  = 1 << KNOB_BITS;
    localparam int KNOB_HALF = 1 << (KNOB_BITS - 1);
    localparam int C99       = (99 * KNOB_ONE + 50) / 100;
    localparam int C01       = (KNOB_ONE + 50) / 100;
    localparam int C95       = (95 * KNOB_ONE + 50) / 100;
    localparam int SMP_MAX   = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMP_MIN   = -(1 << (SAMPLE_BITS - 1));

    // shared multiplier operand widths (signed)
    localparam int MUL_A_W = ((SAMPLE_BITS > KNOB_BITS) ? SAMPLE_BITS : KNOB_BITS) + 4;
    localparam int MUL_B_W = KNOB_BITS + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RND_W   = PROD_W - KNOB_BITS;

    localparam int PHASE_W = KNOB_BITS + 2;
    localparam int Q_W     = SAMPLE_BITS - 1;
    localparam int WET_W   = SAMPLE_BITS + 2;
    localparam int DIFF_W  = SAMPLE_BITS + 3;
    localparam int SUM_W   = RND_W + 1;

    // quantizer divide: (2|x| + q) / (2q)
    localparam int DIV_NUM_W = SAMPLE_BITS + 1;
    localparam int DIV_DEN_W = SAMPLE_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } div_rsp_t;

    // round half up and drop KNOB_BITS fraction bits
    function automatic logic signed [RND_W-1:0] rnd_knob(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + PROD_W'(KNOB_HALF);
        return s[PROD_W-1:KNOB_BITS];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/sshb_if.sv
// sshb_in_if / sshb_out_if: valid-ready channels of the bitcrusher with their
// sample and knob payloads. Depends on sshb_pkg.
`default_nettype none

interface sshb_in_if;
    import sshb_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic [KNOB_BITS-1:0]          rate_knob;
    logic [KNOB_BITS-1:0]          crush_knob;
    logic [KNOB_BITS:0]            mix_amount;

    modport source (
        output valid, sample_left, sample_right, rate_knob, crush_knob, mix_amount,
        input  ready
    );

    modport sink (
        input  valid, sample_left, sample_right, rate_knob, crush_knob, mix_amount,
        output ready
    );
endinterface

interface sshb_out_if;
    import sshb_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    modport source (
        output valid, out_left, out_right,
        input  ready
    );

    modport sink (
        input  valid, out_left, out_right,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/sshb_div.sv
// sshb_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on sshb_pkg (widths and request/response structs).
`default_nettype none

module sshb_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  sshb_pkg::div_req_t     req,
    output sshb_pkg::div_rsp_t     rsp
);
    import sshb_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] qn_reg, qn_next;   // numerator shifts out, quotient shifts in
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 take;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        qn_next   = qn_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        trial     = {rem_reg, qn_reg[DIV_NUM_W-1]};
        take      = (trial >= {1'b0, den_reg});

        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            qn_next   = req.num;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next = take ? DIV_DEN_W'(trial - {1'b0, den_reg}) : trial[DIV_DEN_W-1:0];
            qn_next  = {qn_reg[DIV_NUM_W-2:0], take};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qn_reg  <= qn_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = qn_reg;

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

endmodule

`default_nettype wire

// File: rtl/core/stereo_sample_hold_bitcrusher.sv
// stereo_sample_hold_bitcrusher: sequenced sample-and-hold rate reducer and
// quantizer with dry/wet mix. Depends on sshb_pkg, sshb_if, sshb_div.
//
// sample_in carries one stereo pair plus rate, crush and mix knob values per
// transaction; sample_out returns one processed stereo pair per transaction.
// Each item runs through a small sequencer around one shared 20x18 multiplier
// and a 17-step restoring divider. The knob curves run first, then each channel
// runs quantize divide, requantize, blend and saturate, or passes the held sample
// straight to blend and saturate when the quantizer step rounds to zero.
// sample_in.ready returns in the same cycle that the result becomes valid; the
// divider, run once per channel, takes most of an item's time. sample_in.ready is
// high only while the sequencer is idle.
// The result sits in an output register, so the next item is accepted and
// computed while sample_out is stalled; the sequencer only waits at its final
// step if the previous result has still not been taken.
// Reset clears the phase accumulator and both held samples and leaves the
// block idle with no result pending.
`default_nettype none

module stereo_sample_hold_bitcrusher (
    input  wire logic  clk,
    input  wire logic  rst_n,
    sshb_in_if.sink    sample_in,
    sshb_out_if.source sample_out
);
    import sshb_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_SQ_R     = 4'd1;
    localparam logic [ST_W-1:0] ST_SQ_R2    = 4'd2;
    localparam logic [ST_W-1:0] ST_MUL_C99  = 4'd3;
    localparam logic [ST_W-1:0] ST_PHASE    = 4'd4;
    localparam logic [ST_W-1:0] ST_SQ_D2    = 4'd5;
    localparam logic [ST_W-1:0] ST_MUL_C95  = 4'd6;
    localparam logic [ST_W-1:0] ST_STEP     = 4'd7;
    localparam logic [ST_W-1:0] ST_QUANT    = 4'd8;
    localparam logic [ST_W-1:0] ST_DIV_WAIT = 4'd9;
    localparam logic [ST_W-1:0] ST_WET      = 4'd10;
    localparam logic [ST_W-1:0] ST_BLEND    = 4'd11;
    localparam logic [ST_W-1:0] ST_SAT      = 4'd12;

    logic [ST_W-1:0]               state_reg, state_next;
    logic                          ch_reg, ch_next;
    logic signed [PHASE_W-1:0]     phase_reg, phase_next;
    logic signed [SAMPLE_BITS-1:0] held_l_reg, held_l_next;
    logic signed [SAMPLE_BITS-1:0] held_r_reg, held_r_next;
    logic                          out_valid_reg, out_valid_next;

    logic signed [SAMPLE_BITS-1:0] xl_reg, xl_next;
    logic signed [SAMPLE_BITS-1:0] xr_reg, xr_next;
    logic [KNOB_BITS-1:0]          r_reg, r_next;
    logic [KNOB_BITS-1:0]          c_reg, c_next;
    logic [KNOB_BITS:0]            mix_reg, mix_next;
    logic signed [PROD_W-1:0]      prod_reg, prod_next;
    logic [Q_W-1:0]                q_reg, q_next;
    logic                          neg_reg, neg_next;
    logic signed [WET_W-1:0]       wet_reg, wet_next;
    logic signed [SAMPLE_BITS-1:0] res_l_reg, res_l_next;
    logic signed [SAMPLE_BITS-1:0] out_l_reg, out_l_next;
    logic signed [SAMPLE_BITS-1:0] out_r_reg, out_r_next;

    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [RND_W-1:0]       rnd_v;
    logic [KNOB_BITS:0]            d_val;
    logic [KNOB_BITS-1:0]          inc;
    logic signed [PHASE_W-1:0]     phase_sum;
    logic [KNOB_BITS+SAMPLE_BITS-2:0] q_wide;
    logic signed [SAMPLE_BITS-1:0] x_sel;
    logic signed [SAMPLE_BITS-1:0] dry;
    logic [SAMPLE_BITS-1:0]        ax;
    logic signed [WET_W-1:0]       m_ext;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [SUM_W-1:0]       sat_sum;
    logic signed [SAMPLE_BITS-1:0] sat_v;
    logic                          in_accept;
    logic                          out_take;

    div_req_t div_req;
    div_rsp_t div_rsp;

    sshb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_accept = sample_in.valid && (state_reg == ST_IDLE);
    assign out_take  = out_valid_reg && sample_out.ready;

    assign rnd_v     = rnd_knob(prod_reg);
    assign d_val     = (KNOB_BITS + 1)'(KNOB_ONE) - {1'b0, c_reg};
    assign inc       = rnd_v[KNOB_BITS-1:0] + KNOB_BITS'(C01);
    assign phase_sum = phase_reg + $signed({2'b00, inc});
    // q = round(step * 2^(S-1) / 2^K)
    assign q_wide    = {rnd_v[KNOB_BITS-1:0], (SAMPLE_BITS - 1)'(0)}
                     + (KNOB_BITS + SAMPLE_BITS - 1)'(KNOB_HALF);
    assign x_sel     = ch_reg ? held_r_reg : held_l_reg;
    assign dry       = ch_reg ? xr_reg : xl_reg;
    assign ax        = x_sel[SAMPLE_BITS-1] ? (~x_sel + 1'b1) : x_sel;
    assign m_ext     = WET_W'(prod_reg[SAMPLE_BITS:0]);
    assign diff      = DIFF_W'(wet_reg) - DIFF_W'(dry);
    assign sat_sum   = SUM_W'(dry) + SUM_W'(rnd_v);

    always_comb
    begin
        if (sat_sum > $signed(SUM_W'(SMP_MAX)))
            sat_v = SAMPLE_BITS'(SMP_MAX);
        else if (sat_sum < $signed(SUM_W'(SMP_MIN)))
            sat_v = SAMPLE_BITS'(SMP_MIN);
        else
            sat_v = sat_sum[SAMPLE_BITS-1:0];
    end

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_SQ_R:
            begin
                mul_a = MUL_A_W'(r_reg);
                mul_b = MUL_B_W'(r_reg);
            end
            ST_SQ_R2, ST_SQ_D2:
            begin
                mul_a = MUL_A_W'(rnd_v[KNOB_BITS:0]);
                mul_b = MUL_B_W'(rnd_v[KNOB_BITS:0]);
            end
            ST_MUL_C99:
            begin
                mul_a = MUL_A_W'(rnd_v[KNOB_BITS:0]);
                mul_b = MUL_B_W'(C99);
            end
            ST_PHASE:
            begin
                mul_a = MUL_A_W'(d_val);
                mul_b = MUL_B_W'(d_val);
            end
            ST_MUL_C95:
            begin
                mul_a = MUL_A_W'(rnd_v[KNOB_BITS:0]);
                mul_b = MUL_B_W'(C95);
            end
            ST_DIV_WAIT:
            begin
                mul_a = MUL_A_W'(div_rsp.quot);
                mul_b = MUL_B_W'(q_reg);
            end
            // blend product is kept while the final step waits on sample_out
            ST_BLEND, ST_SAT:
            begin
                mul_a = MUL_A_W'(diff);
                mul_b = MUL_B_W'(mix_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        phase_next     = phase_reg;
        held_l_next    = held_l_reg;
        held_r_next    = held_r_reg;
        out_valid_next = out_valid_reg;
        xl_next        = xl_reg;
        xr_next        = xr_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        mix_next       = mix_reg;
        q_next         = q_reg;
        neg_next       = neg_reg;
        wet_next       = wet_reg;
        res_l_next     = res_l_reg;
        out_l_next     = out_l_reg;
        out_r_next     = out_r_reg;
        div_req.start  = 1'b0;
        div_req.num    = {ax, 1'b0} + DIV_NUM_W'(q_reg);
        div_req.den    = {q_reg, 1'b0};

        if (out_take)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    xl_next = sample_in.sample_left;
                    xr_next = sample_in.sample_right;
                    r_next  = sample_in.rate_knob;
                    c_next  = sample_in.crush_knob;
                    // mix above one acts as fully wet
                    if (sample_in.mix_amount[KNOB_BITS] && |sample_in.mix_amount[KNOB_BITS-1:0])
                        mix_next = (KNOB_BITS + 1)'(KNOB_ONE);
                    else
                        mix_next = sample_in.mix_amount;
                    state_next = ST_SQ_R;
                end
            end
            ST_SQ_R:    state_next = ST_SQ_R2;
            ST_SQ_R2:   state_next = ST_MUL_C99;
            ST_MUL_C99: state_next = ST_PHASE;
            ST_PHASE:
            begin
                if (phase_sum >= $signed(PHASE_W'(KNOB_HALF)))
                begin
                    held_l_next = xl_reg;
                    held_r_next = xr_reg;
                    phase_next  = phase_sum - PHASE_W'(KNOB_ONE);
                end
                else
                begin
                    phase_next = phase_sum;
                end
                state_next = ST_SQ_D2;
            end
            ST_SQ_D2:   state_next = ST_MUL_C95;
            ST_MUL_C95: state_next = ST_STEP;
            ST_STEP:
            begin
                q_next     = q_wide[KNOB_BITS +: Q_W];
                ch_next    = 1'b0;
                state_next = ST_QUANT;
            end
            ST_QUANT:
            begin
                neg_next = x_sel[SAMPLE_BITS-1];
                if (q_reg == '0)
                begin
                    // zero step passes the held sample through
                    wet_next   = WET_W'(x_sel);
                    state_next = ST_BLEND;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_WET;
            end
            ST_WET:
            begin
                wet_next   = neg_reg ? -m_ext : m_ext;
                state_next = ST_BLEND;
            end
            ST_BLEND:   state_next = ST_SAT;
            ST_SAT:
            begin
                if (!ch_reg)
                begin
                    res_l_next = sat_v;
                    ch_next    = 1'b1;
                    state_next = ST_QUANT;
                end
                else if (!out_valid_reg || sample_out.ready)
                begin
                    out_l_next     = res_l_reg;
                    out_r_next     = sat_v;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= 1'b0;
            phase_reg     <= '0;
            held_l_reg    <= '0;
            held_r_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            phase_reg     <= phase_next;
            held_l_reg    <= held_l_next;
            held_r_reg    <= held_r_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xl_reg    <= xl_next;
        xr_reg    <= xr_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        mix_reg   <= mix_next;
        prod_reg  <= prod_next;
        q_reg     <= q_next;
        neg_reg   <= neg_next;
        wet_reg   <= wet_next;
        res_l_reg <= res_l_next;
        out_l_reg <= out_l_next;
        out_r_reg <= out_r_next;
    end

    assign sample_in.ready      = (state_reg == ST_IDLE);
    assign sample_out.valid     = out_valid_reg;
    assign sample_out.out_left  = out_l_reg;
    assign sample_out.out_right = out_r_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !sample_in.ready)
        else $error("input accepted again before the item finished");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg >= $signed(-PHASE_W'(KNOB_HALF)) && phase_reg < $signed(PHASE_W'(KNOB_HALF)))
        else $error("phase accumulator out of range");

    a_result_from_sat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SAT) && $past(ch_reg))
        else $error("result raised outside the final saturate step");

endmodule

`default_nettype wire

// File: bench/tb_stereo_sample_hold_bitcrusher.sv
// tb_stereo_sample_hold_bitcrusher: self-checking bench for the stereo sample-and-hold
// bitcrusher: a directed table, then random traffic with bursty stalls on both channels.
// Depends on sshb_pkg, sshb_if and the stereo_sample_hold_bitcrusher RTL.
`default_nettype none

module tb_stereo_sample_hold_bitcrusher;
    timeunit 1ns;
    timeprecision 1ps;

    import sshb_pkg::*;

    localparam int DIR_COUNT    = 20;
    localparam int RANDOM_ITEMS = 1030;
    localparam int CALM_ITEMS   = 150;
    localparam int ITEM_LATENCY = 52;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
        logic [KNOB_BITS-1:0]   rate;
        logic [KNOB_BITS-1:0]   crush;
        logic [KNOB_BITS:0]     mix;
    } crush_in_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left;
        logic [SAMPLE_BITS-1:0] right;
    } stereo_out_t;

    typedef struct packed {
        bit          typed;
        stereo_out_t want;
        crush_in_t   stim;
    } dir_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sshb_in_if  sample_in ();
    sshb_out_if sample_out ();

    stereo_sample_hold_bitcrusher uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in),
        .sample_out (sample_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    logic signed [PHASE_W-1:0]     phase_acc;
    logic signed [SAMPLE_BITS-1:0] hold_l;
    logic signed [SAMPLE_BITS-1:0] hold_r;

    stereo_out_t expected_pairs[$];
    int          mismatches    = 0;
    int          pairs_checked = 0;
    int          items_sent    = 0;
    int          captures      = 0;
    int          zero_steps    = 0;
    bit          calm          = 1'b0;
    int          quiet_cycles  = 0;

    // directed rows: extremes, zero step, coarsest step, overshoot, mix above one
    dir_row_t dir_rows [DIR_COUNT] = '{
        '{1'b1, '{16'sd0, 16'sd0},
          '{16'sd32767, -16'sd32768, 16'd0, 16'd65535, 17'd65536}},
        '{1'b1, '{-16'sd32768, 16'sd32767},
          '{-16'sd32768, 16'sd32767, 16'd0, 16'd0, 17'd0}},
        '{1'b1, '{16'sd0, 16'sd0},
          '{16'sd0, 16'sd0, 16'd65535, 16'd32768, 17'd0}},
        '{1'b1, '{16'sd32767, -16'sd32768},
          '{16'sd32767, -16'sd32768, 16'd65535, 16'd65535, 17'd0}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd32767, -16'sd32768, 16'd65535, 16'd0, 17'd65536}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{-16'sd1, 16'sd1, 16'd65535, 16'd0, 17'd65536}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd12345, -16'sd12345, 16'd0, 16'd20000, 17'd65536}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd32767, -16'sd32768, 16'd65535, 16'd30000, 17'd65536}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd1000, -16'sd1000, 16'd65535, 16'd40000, 17'd32768}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{-16'sd20000, 16'sd20000, 16'd32768, 16'd50000, 17'd131071}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd5, -16'sd5, 16'd16384, 16'd60000, 17'd65537}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd32767, -16'sd32768, 16'd49152, 16'd65354, 17'd100000}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{-16'sd32768, 16'sd32767, 16'd65535, 16'd65353, 17'd65536}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd0, 16'sd0, 16'd1, 16'd1, 17'd1}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd16384, -16'sd16384, 16'd65535, 16'd45000, 17'd65535}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd777, -16'sd778, 16'd40000, 16'd62000, 17'd65536}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{-16'sd32768, -16'sd32768, 16'd65535, 16'd10000, 17'd49152}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd32767, 16'sd32767, 16'd65535, 16'd55000, 17'd65536}},
        '{1'b0, '{16'sd0, 16'sd0},
          '{16'sd3, -16'sd3, 16'd0, 16'd65535, 17'd131071}},
        '{1'b1, '{-16'sd7, 16'sd7},
          '{-16'sd7, 16'sd7, 16'd65535, 16'd64000, 17'd0}}
    };

    function automatic longint round_knob(longint v);
        return (v + (longint'(1) <<< (KNOB_BITS - 1))) >>> KNOB_BITS;
    endfunction

    // nearest multiple of q, ties away from zero
    function automatic longint snap_to_step(longint x, longint q);
        longint ax;
        longint m;
        if (q == 0)
            return x;
        ax = (x < 0) ? -x : x;
        m  = ((2 * ax + q) / (2 * q)) * q;
        return (x < 0) ? -m : m;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] mix_and_clip(longint dry, longint wet,
                                                            longint m);
        longint v;
        v = dry + round_knob((wet - dry) * m);
        if (v > SMP_MAX)
            v = SMP_MAX;
        if (v < SMP_MIN)
            v = SMP_MIN;
        return SAMPLE_BITS'(v);
    endfunction

    task automatic predict_crush(input crush_in_t it, output stereo_out_t res);
        longint xl, xr, r, c, m, r2, r4, inc, d, d2, d4, stp, q, ph;
        xl = longint'($signed(it.left));
        xr = longint'($signed(it.right));
        r  = longint'(it.rate);
        c  = longint'(it.crush);
        m  = longint'(it.mix);
        if (m > KNOB_ONE)
            m = KNOB_ONE;

        r2  = round_knob(r * r);
        r4  = round_knob(r2 * r2);
        inc = round_knob(r4 * C99) + C01;

        ph = longint'(phase_acc) + inc;
        if (ph >= KNOB_HALF)
        begin
            hold_l = SAMPLE_BITS'(xl);
            hold_r = SAMPLE_BITS'(xr);
            ph     = ph - KNOB_ONE;
            captures++;
        end
        phase_acc = PHASE_W'(ph);

        d   = KNOB_ONE - c;
        d2  = round_knob(d * d);
        d4  = round_knob(d2 * d2);
        stp = round_knob(d4 * C95);
        q   = round_knob(stp * (longint'(1) <<< (SAMPLE_BITS - 1)));
        if (q == 0)
            zero_steps++;

        res.left  = mix_and_clip(xl, snap_to_step(longint'(hold_l), q), m);
        res.right = mix_and_clip(xr, snap_to_step(longint'(hold_r), q), m);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        stereo_out_t want;
        if (rst_n && sample_out.valid && sample_out.ready)
        begin
            if (expected_pairs.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %h/%h",
                                          sample_out.out_left, sample_out.out_right));
            end
            else
            begin
                want = expected_pairs.pop_front();
                if (sample_out.out_left !== want.left)
                    report_mismatch($sformatf("result %0d out_left got %h want %h",
                                              pairs_checked, sample_out.out_left, want.left));
                if (sample_out.out_right !== want.right)
                    report_mismatch($sformatf("result %0d out_right got %h want %h",
                                              pairs_checked, sample_out.out_right, want.right));
                pairs_checked++;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((sample_in.valid && sample_in.ready) || (sample_out.valid && sample_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: bursty stalls, none in the calm tail
    initial
    begin
        bit stalls_on;
        sample_out.ready <= 1'b0;
        stalls_on = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                stalls_on = !stalls_on;
            if (!calm && stalls_on && $urandom_range(0, 2) == 0)
            begin
                sample_out.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            sample_out.ready <= 1'b1;
            repeat ($urandom_range(1, 25)) @(posedge clk);
        end
    end

    // stimulus
    initial
    begin
        crush_in_t   it;
        stereo_out_t pred;
        bit          gaps_on;
        int          total;
        sample_in.valid        <= 1'b0;
        sample_in.sample_left  <= '0;
        sample_in.sample_right <= '0;
        sample_in.rate_knob    <= '0;
        sample_in.crush_knob   <= '0;
        sample_in.mix_amount   <= '0;
        phase_acc = '0;
        hold_l    = '0;
        hold_r    = '0;
        gaps_on   = 1'b1;
        total     = DIR_COUNT + RANDOM_ITEMS;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < total; n++)
        begin
            if (n < DIR_COUNT)
            begin
                it = dir_rows[n].stim;
            end
            else
            begin
                it.left  = SAMPLE_BITS'($urandom);
                it.right = SAMPLE_BITS'($urandom);
                if ($urandom_range(0, 7) == 0)
                    it.left = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                if ($urandom_range(0, 7) == 0)
                    it.right = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                case ($urandom_range(0, 9))
                    0:       it.rate = '0;
                    1:       it.rate = '1;
                    default: it.rate = KNOB_BITS'($urandom);
                endcase
                // bias the crush knob toward the small and zero step region
                case ($urandom_range(0, 9))
                    0:       it.crush = '0;
                    1, 2, 3: it.crush = KNOB_BITS'($urandom_range(65535, 65300));
                    default: it.crush = KNOB_BITS'($urandom);
                endcase
                case ($urandom_range(0, 9))
                    0:       it.mix = '0;
                    1, 2:    it.mix = (KNOB_BITS+1)'(KNOB_ONE);
                    3:       it.mix = (KNOB_BITS+1)'($urandom_range(131071, KNOB_ONE + 1));
                    default: it.mix = (KNOB_BITS+1)'($urandom_range(KNOB_ONE, 0));
                endcase
            end

            calm = (n >= total - CALM_ITEMS);
            if ($urandom_range(0, 19) == 0)
                gaps_on = !gaps_on;
            if (!calm && gaps_on && $urandom_range(0, 2) == 0)
            begin
                sample_in.valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end

            sample_in.valid        <= 1'b1;
            sample_in.sample_left  <= it.left;
            sample_in.sample_right <= it.right;
            sample_in.rate_knob    <= it.rate;
            sample_in.crush_knob   <= it.crush;
            sample_in.mix_amount   <= it.mix;
            do
                @(posedge clk);
            while (!sample_in.ready);

            // transaction accepted at this edge
            predict_crush(it, pred);
            if (n < DIR_COUNT && dir_rows[n].typed)
                expected_pairs.push_back(dir_rows[n].want);
            else
                expected_pairs.push_back(pred);
            items_sent++;
        end
        sample_in.valid <= 1'b0;

        while (expected_pairs.size() != 0)
            @(posedge clk);
        repeat (4 * ITEM_LATENCY) @(posedge clk);

        $display("sent %0d stereo items (%0d directed), checked %0d results",
                 items_sent, DIR_COUNT, pairs_checked);
        $display("held pair refreshed %0d times, %0d items ran with a zero quantizer step",
                 captures, zero_steps);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
